[hdl/ffgrp_pkg.sv]
package ffgrp_pkg;

    // Default grid geometry and tag width
    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;
    localparam int TAG_BITS_DEF = 8;

    // Port field widths
    localparam int OP_W       = 2;
    localparam int DIM_W      = 5;
    localparam int TAGF_W     = 8;
    localparam int CELL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PLACE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOCK_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOCK_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TAG  = 2'd2;

    // Configuration reset values
    localparam logic [DIM_W-1:0]  STOCK_ROWS_RST = 5'd16;
    localparam logic [DIM_W-1:0]  STOCK_COLS_RST = 5'd16;
    localparam logic [TAGF_W-1:0] EMPTY_TAG_RST  = 8'd0;

endpackage

[hdl/ffgrp_ram.sv]
module ffgrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/first_fit_grid_rectangle_placer.sv]
// Clear rewrites every grid cell with the empty tag; a refused place goes straight to the result.
// Place: each footprint cell checked takes one grid memory read, then a compare,
//   over all anchors tried, then one write per footprint cell.
// One request in flight at a time.
// Reset: aresetn (synchronous, active low) clears control state, then a sweep
//   writes zero into all MAX_ROWS*MAX_COLS grid cells while s_ready stays low.
module first_fit_grid_rectangle_placer #(
    parameter int MAX_ROWS = ffgrp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = ffgrp_pkg::MAX_COLS_DEF,
    parameter int TAG_BITS = ffgrp_pkg::TAG_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [ffgrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffgrp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ffgrp_pkg::OP_W-1:0]          s_operation,
    input  logic [ffgrp_pkg::DIM_W-1:0]         s_piece_rows,
    input  logic [ffgrp_pkg::DIM_W-1:0]         s_piece_cols,
    input  logic [ffgrp_pkg::TAGF_W-1:0]        s_piece_tag,
    input  logic                                s_already_cut,
    input  logic [ffgrp_pkg::CELL_W-1:0]        s_cell_row,
    input  logic [ffgrp_pkg::CELL_W-1:0]        s_cell_col,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_placed,
    output logic [ffgrp_pkg::TAGF_W-1:0]        m_cell_value
);

    // Geometry
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int RD    = $clog2(MAX_ROWS + 1);
    localparam int CD    = $clog2(MAX_COLS + 1);
    localparam int DW0   = RD > CD ? RD : CD;
    // dimension / counter width: holds every sheet size and piece size
    localparam int DW    = DW0 > ffgrp_pkg::DIM_W ? DW0 : ffgrp_pkg::DIM_W;
    // one extra bit for anchor-plus-size sums
    localparam int XW    = DW + 1;

    // One-hot sequencer states
    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,  // post-reset grid sweep
        S_IDLE  = 8'b0000_0010,
        S_CLEAR = 8'b0000_0100,  // refill grid with empty tag
        S_READ  = 8'b0000_1000,  // issue footprint cell read
        S_CMP   = 8'b0001_0000,  // compare returned cell with empty tag
        S_WRITE = 8'b0010_0000,  // write piece tag over footprint
        S_CELL  = 8'b0100_0000,  // capture single-cell read
        S_DONE  = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [ffgrp_pkg::DIM_W-1:0] stock_rows_reg, stock_rows_next;
    logic [ffgrp_pkg::DIM_W-1:0] stock_cols_reg, stock_cols_next;
    logic [TAG_BITS-1:0]         empty_tag_reg, empty_tag_next;

    // Request and scan registers
    logic [DW-1:0]       pr_reg, pr_next;
    logic [DW-1:0]       pc_reg, pc_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [DW-1:0]       ar_reg, ar_next;
    logic [DW-1:0]       ac_reg, ac_next;
    logic [DW-1:0]       fr_reg, fr_next;
    logic [DW-1:0]       fc_reg, fc_next;
    logic [AW-1:0]       idx_reg, idx_next;

    // Pending result and output register
    logic                        res_placed_reg, res_placed_next;
    logic [ffgrp_pkg::TAGF_W-1:0] res_value_reg, res_value_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_placed_reg, m_placed_next;
    logic [ffgrp_pkg::TAGF_W-1:0] m_value_reg, m_value_next;

    // Grid memory ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [TAG_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [TAG_BITS-1:0] ram_rdata;

    // Datapath helpers
    logic [DW-1:0] rows_eff, cols_eff;
    logic [DW-1:0] in_pr, in_pc;
    logic [DW-1:0] cur_row, cur_col;
    logic [AW-1:0] scan_addr, cell_addr;
    logic          cell_in_grid;
    logic          place_ok;
    logic          fc_last, fr_last, col_end, row_end, idx_last;
    logic          cell_free;
    logic          out_free;
    logic          accept;

    // Sheet size saturates at the grid size
    assign rows_eff = (DW'(stock_rows_reg) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS)
                                                             : DW'(stock_rows_reg);
    assign cols_eff = (DW'(stock_cols_reg) > DW'(MAX_COLS)) ? DW'(MAX_COLS)
                                                             : DW'(stock_cols_reg);

    assign in_pr = DW'(s_piece_rows);
    assign in_pc = DW'(s_piece_cols);

    // Refuse cut, empty or oversize pieces before any scan
    assign place_ok = !s_already_cut && (in_pr != '0) && (in_pc != '0) &&
                      (in_pr <= rows_eff) && (in_pc <= cols_eff);

    // Current footprint cell, row-major grid address
    assign cur_row   = ar_reg + fr_reg;
    assign cur_col   = ac_reg + fc_reg;
    assign scan_addr = AW'(32'(cur_row) * MAX_COLS + 32'(cur_col));
    assign cell_addr = AW'(32'(s_cell_row) * MAX_COLS + 32'(s_cell_col));
    assign cell_in_grid = (32'(s_cell_row) < MAX_ROWS) && (32'(s_cell_col) < MAX_COLS);

    assign fc_last  = (XW'(fc_reg) + XW'(1)) == XW'(pc_reg);
    assign fr_last  = (XW'(fr_reg) + XW'(1)) == XW'(pr_reg);
    assign col_end  = (XW'(ac_reg) + XW'(1) + XW'(pc_reg)) > XW'(cols_eff);
    assign row_end  = (XW'(ar_reg) + XW'(1) + XW'(pr_reg)) > XW'(rows_eff);
    assign idx_last = idx_reg == AW'(DEPTH - 1);
    assign cell_free = ram_rdata == empty_tag_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign accept   = s_valid && s_ready;

    // Grid memory access: sweeps and footprint writes share the write port,
    // footprint checks and single-cell reads share the read port.
    always_comb begin
        ram_we    = (state_reg == S_INIT) || (state_reg == S_CLEAR) ||
                    (state_reg == S_WRITE);
        ram_waddr = (state_reg == S_WRITE) ? scan_addr : idx_reg;
        if (state_reg == S_INIT) begin
            ram_wdata = '0;
        end else if (state_reg == S_CLEAR) begin
            ram_wdata = empty_tag_reg;
        end else begin
            ram_wdata = tag_reg;
        end
        ram_re    = (state_reg == S_READ) || accept;
        ram_raddr = (state_reg == S_READ) ? scan_addr : cell_addr;
    end

    ffgrp_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_comb begin
        stock_rows_next = stock_rows_reg;
        stock_cols_next = stock_cols_reg;
        empty_tag_next  = empty_tag_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                ffgrp_pkg::REG_STOCK_ROWS: stock_rows_next = cfg_wdata[ffgrp_pkg::DIM_W-1:0];
                ffgrp_pkg::REG_STOCK_COLS: stock_cols_next = cfg_wdata[ffgrp_pkg::DIM_W-1:0];
                ffgrp_pkg::REG_EMPTY_TAG:  empty_tag_next  = TAG_BITS'(cfg_wdata);
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        pr_next         = pr_reg;
        pc_next         = pc_reg;
        tag_next        = tag_reg;
        rd_ok_next      = rd_ok_reg;
        ar_next         = ar_reg;
        ac_next         = ac_reg;
        fr_next         = fr_reg;
        fc_next         = fc_reg;
        idx_next        = idx_reg;
        res_placed_next = res_placed_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_placed_next   = m_placed_reg;
        m_value_next    = m_value_reg;

        // retire the waiting result
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                idx_next = idx_reg + AW'(1);
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_placed_next = 1'b0;
                    res_value_next  = '0;
                    pr_next         = in_pr;
                    pc_next         = in_pc;
                    tag_next        = TAG_BITS'(s_piece_tag);
                    rd_ok_next      = cell_in_grid;
                    ar_next         = '0;
                    ac_next         = '0;
                    fr_next         = '0;
                    fc_next         = '0;
                    idx_next        = '0;
                    unique case (s_operation)
                        ffgrp_pkg::OP_PLACE: state_next = place_ok ? S_READ : S_DONE;
                        ffgrp_pkg::OP_CLEAR: state_next = S_CLEAR;
                        ffgrp_pkg::OP_READ:  state_next = S_CELL;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                idx_next = idx_reg + AW'(1);
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (cell_free) begin
                    // advance through the footprint
                    state_next = S_READ;
                    if (fc_last) begin
                        fc_next = '0;
                        if (fr_last) begin
                            fr_next    = '0;
                            state_next = S_WRITE;
                        end else begin
                            fr_next = fr_reg + DW'(1);
                        end
                    end else begin
                        fc_next = fc_reg + DW'(1);
                    end
                end else begin
                    // occupied: move to the next anchor in row-major order
                    fr_next    = '0;
                    fc_next    = '0;
                    state_next = S_READ;
                    if (col_end) begin
                        ac_next = '0;
                        if (row_end) begin
                            res_placed_next = 1'b0;
                            state_next      = S_DONE;
                        end else begin
                            ar_next = ar_reg + DW'(1);
                        end
                    end else begin
                        ac_next = ac_reg + DW'(1);
                    end
                end
            end
            S_WRITE: begin
                if (fc_last) begin
                    fc_next = '0;
                    if (fr_last) begin
                        fr_next         = '0;
                        res_placed_next = 1'b1;
                        state_next      = S_DONE;
                    end else begin
                        fr_next = fr_reg + DW'(1);
                    end
                end else begin
                    fc_next = fc_reg + DW'(1);
                end
            end
            S_CELL: begin
                res_value_next = rd_ok_reg ? ffgrp_pkg::TAGF_W'(ram_rdata) : '0;
                state_next     = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_placed_next = res_placed_reg;
                    m_value_next  = res_value_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
            stock_rows_reg <= ffgrp_pkg::STOCK_ROWS_RST;
            stock_cols_reg <= ffgrp_pkg::STOCK_COLS_RST;
            empty_tag_reg  <= TAG_BITS'(ffgrp_pkg::EMPTY_TAG_RST);
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            stock_rows_reg <= stock_rows_next;
            stock_cols_reg <= stock_cols_next;
            empty_tag_reg  <= empty_tag_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pr_reg         <= pr_next;
        pc_reg         <= pc_next;
        tag_reg        <= tag_next;
        rd_ok_reg      <= rd_ok_next;
        ar_reg         <= ar_next;
        ac_reg         <= ac_next;
        fr_reg         <= fr_next;
        fc_reg         <= fc_next;
        res_placed_reg <= res_placed_next;
        res_value_reg  <= res_value_next;
        m_placed_reg   <= m_placed_next;
        m_value_reg    <= m_value_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_placed     = m_placed_reg;
    assign m_cell_value = m_value_reg;

`ifndef SYNTH
    // A compare always sees data from the read issued in the previous cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> $past(state_reg == S_READ))
        else $error("compare without a preceding grid read");

    // No grid write while a footprint check is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ || state_reg == S_CMP) |-> !ram_we)
        else $error("grid written during footprint check");

    // Footprint writes stay inside the sheet
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (cur_row < rows_eff && cur_col < cols_eff))
        else $error("footprint write outside the sheet");

    // A successful placement never carries a cell value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_placed_reg) |-> (m_value_reg == '0))
        else $error("placed result with nonzero cell value");
`endif

endmodule

[tb/first_fit_grid_rectangle_placer_test.sv]
module first_fit_grid_rectangle_placer_test;

    localparam int GRID_ROWS   = ffgrp_pkg::MAX_ROWS_DEF;
    localparam int GRID_COLS   = ffgrp_pkg::MAX_COLS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 9;

    // Operation code 3 has no meaning in the block; it must leave the grid alone.
    localparam logic [ffgrp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Sheet settings for the random phases. Rows of 31 saturate to the grid,
    // rows of 0 give an empty sheet on which every placement fails.
    localparam int PHASE_ROWS  [PHASES] = '{16, 1, 16, 1, 0, 31, 5, 3, 8};
    localparam int PHASE_COLS  [PHASES] = '{16, 1, 1, 16, 9, 5, 7, 4, 12};
    localparam int PHASE_FREE  [PHASES] = '{8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h55,
                                            8'h80, 8'h01, 8'hFE, 8'h00};
    localparam int PHASE_ITEMS [PHASES] = '{180, 80, 120, 120, 40, 160, 160, 120, 200};

    typedef struct {
        logic [ffgrp_pkg::OP_W-1:0]   operation;
        logic [ffgrp_pkg::DIM_W-1:0]  piece_rows;
        logic [ffgrp_pkg::DIM_W-1:0]  piece_cols;
        logic [ffgrp_pkg::TAGF_W-1:0] piece_tag;
        logic                         already_cut;
        logic [ffgrp_pkg::CELL_W-1:0] cell_row;
        logic [ffgrp_pkg::CELL_W-1:0] cell_col;
    } request_t;

    typedef struct {
        logic                         placed;
        logic [ffgrp_pkg::TAGF_W-1:0] cell_value;
    } outcome_t;

    // Shadow of the occupancy grid and the sheet registers. Every accepted
    // request is applied here in order, and the outcome it must produce is
    // queued until the block returns its result.
    class placement_scoreboard;
        logic [ffgrp_pkg::TAGF_W-1:0] grid [GRID_ROWS][GRID_COLS];
        logic [ffgrp_pkg::DIM_W-1:0]  sheet_rows;
        logic [ffgrp_pkg::DIM_W-1:0]  sheet_cols;
        logic [ffgrp_pkg::TAGF_W-1:0] free_tag;
        outcome_t                     pending_outcomes [$];
        int                           mismatches;

        function new();
            foreach (grid[r, c]) grid[r][c] = '0;
            sheet_rows = ffgrp_pkg::STOCK_ROWS_RST;
            sheet_cols = ffgrp_pkg::STOCK_COLS_RST;
            free_tag   = ffgrp_pkg::EMPTY_TAG_RST;
            mismatches = 0;
        endfunction

        function void write_register(logic [ffgrp_pkg::CFG_IDX_W-1:0] idx,
                                     logic [ffgrp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ffgrp_pkg::REG_STOCK_ROWS: sheet_rows = data[ffgrp_pkg::DIM_W-1:0];
                ffgrp_pkg::REG_STOCK_COLS: sheet_cols = data[ffgrp_pkg::DIM_W-1:0];
                ffgrp_pkg::REG_EMPTY_TAG:  free_tag   = data;
                default: ;
            endcase
        endfunction

        function bit footprint_free(int r0, int c0, int pr, int pc);
            int r, c;
            for (r = r0; r < r0 + pr; r++)
                for (c = c0; c < c0 + pc; c++)
                    if (grid[r][c] != free_tag)
                        return 1'b0;
            return 1'b1;
        endfunction

        // Scan anchors row-major over the sheet and take the first free footprint.
        function bit first_fit_place(int pr, int pc, logic [ffgrp_pkg::TAGF_W-1:0] tag,
                                     logic cut);
            int rows, cols, r0, c0, r, c;
            rows = (sheet_rows > GRID_ROWS) ? GRID_ROWS : int'(sheet_rows);
            cols = (sheet_cols > GRID_COLS) ? GRID_COLS : int'(sheet_cols);
            if (cut || pr == 0 || pc == 0 || pr > rows || pc > cols)
                return 1'b0;
            for (r0 = 0; r0 + pr <= rows; r0++) begin
                for (c0 = 0; c0 + pc <= cols; c0++) begin
                    if (footprint_free(r0, c0, pr, pc)) begin
                        for (r = r0; r < r0 + pr; r++)
                            for (c = c0; c < c0 + pc; c++)
                                grid[r][c] = tag;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_request(request_t rq);
            outcome_t res;
            res.placed     = 1'b0;
            res.cell_value = '0;
            case (rq.operation)
                ffgrp_pkg::OP_PLACE: res.placed = first_fit_place(int'(rq.piece_rows),
                                                                  int'(rq.piece_cols),
                                                                  rq.piece_tag,
                                                                  rq.already_cut);
                ffgrp_pkg::OP_CLEAR: foreach (grid[r, c]) grid[r][c] = free_tag;
                // a 4-bit address cannot leave the 16 x 16 grid
                ffgrp_pkg::OP_READ:  res.cell_value = grid[rq.cell_row][rq.cell_col];
                default: ;
            endcase
            pending_outcomes.push_back(res);
        endfunction

        function void flag_error(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s", $time, what);
        endfunction

        function void check_result(logic placed, logic [ffgrp_pkg::TAGF_W-1:0] value);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                flag_error($sformatf("result with no request pending: placed=%0b cell_value=%02h",
                                     placed, value));
                return;
            end
            want = pending_outcomes.pop_front();
            if (placed !== want.placed || value !== want.cell_value)
                flag_error($sformatf({"expected placed=%0b cell_value=%02h, ",
                                      "got placed=%0b cell_value=%02h"},
                                     want.placed, want.cell_value, placed, value));
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [ffgrp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ffgrp_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [ffgrp_pkg::OP_W-1:0]       s_operation;
    logic [ffgrp_pkg::DIM_W-1:0]      s_piece_rows;
    logic [ffgrp_pkg::DIM_W-1:0]      s_piece_cols;
    logic [ffgrp_pkg::TAGF_W-1:0]     s_piece_tag;
    logic                             s_already_cut;
    logic [ffgrp_pkg::CELL_W-1:0]     s_cell_row;
    logic [ffgrp_pkg::CELL_W-1:0]     s_cell_col;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_placed;
    logic [ffgrp_pkg::TAGF_W-1:0]     m_cell_value;

    placement_scoreboard board = new();

    // Idle-free stretches on both sides while set.
    bit calm = 1'b0;
    // Raised by the stimulus once; the result side then holds off for a long stretch.
    bit hold_output = 1'b0;

    // Effective sheet and free tag of the current phase, used to shape the stimulus.
    int                           rows_now = GRID_ROWS;
    int                           cols_now = GRID_COLS;
    logic [ffgrp_pkg::TAGF_W-1:0] free_now = ffgrp_pkg::EMPTY_TAG_RST;

    first_fit_grid_rectangle_placer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_piece_rows  (s_piece_rows),
        .s_piece_cols  (s_piece_cols),
        .s_piece_tag   (s_piece_tag),
        .s_already_cut (s_already_cut),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_placed      (m_placed),
        .m_cell_value  (m_cell_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one; none during calm phases.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic request_t compose_request(logic [ffgrp_pkg::OP_W-1:0] op, int pr, int pc,
                                                 int tag, bit cut, int row, int col);
        request_t rq;
        rq.operation   = op;
        rq.piece_rows  = pr[ffgrp_pkg::DIM_W-1:0];
        rq.piece_cols  = pc[ffgrp_pkg::DIM_W-1:0];
        rq.piece_tag   = tag[ffgrp_pkg::TAGF_W-1:0];
        rq.already_cut = cut;
        rq.cell_row    = row[ffgrp_pkg::CELL_W-1:0];
        rq.cell_col    = col[ffgrp_pkg::CELL_W-1:0];
        return rq;
    endfunction

    // Mostly well-formed placements of small pieces, so the grid fills and the
    // scan has to skip occupied anchors; clears keep the grid from saturating.
    function automatic request_t random_request();
        request_t rq;
        int       roll, small_r, small_c;
        rq.piece_tag   = ffgrp_pkg::TAGF_W'($urandom);
        rq.cell_row    = ffgrp_pkg::CELL_W'($urandom);
        rq.cell_col    = ffgrp_pkg::CELL_W'($urandom);
        rq.already_cut = ($urandom_range(0, 19) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 5)
            rq.operation = ffgrp_pkg::OP_CLEAR;
        else if (roll < 25)
            rq.operation = ffgrp_pkg::OP_READ;
        else if (roll < 29)
            rq.operation = OP_UNUSED;
        else
            rq.operation = ffgrp_pkg::OP_PLACE;
        small_r = (rows_now < 1) ? 1 : ((rows_now > 3) ? 3 : rows_now);
        small_c = (cols_now < 1) ? 1 : ((cols_now > 3) ? 3 : cols_now);
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            rq.piece_rows = ffgrp_pkg::DIM_W'($urandom_range(1, small_r));
            rq.piece_cols = ffgrp_pkg::DIM_W'($urandom_range(1, small_c));
        end else if (roll < 93) begin
            rq.piece_rows = ffgrp_pkg::DIM_W'($urandom_range(1, (rows_now < 1) ? 1 : rows_now));
            rq.piece_cols = ffgrp_pkg::DIM_W'($urandom_range(1, (cols_now < 1) ? 1 : cols_now));
        end else begin
            // full field range: zero, oversize and every high bit
            rq.piece_rows = ffgrp_pkg::DIM_W'($urandom);
            rq.piece_cols = ffgrp_pkg::DIM_W'($urandom);
        end
        if ($urandom_range(0, 9) == 0)
            rq.piece_tag = free_now;
        return rq;
    endfunction

    task automatic put_payload(input request_t rq);
        s_operation   <= rq.operation;
        s_piece_rows  <= rq.piece_rows;
        s_piece_cols  <= rq.piece_cols;
        s_piece_tag   <= rq.piece_tag;
        s_already_cut <= rq.already_cut;
        s_cell_row    <= rq.cell_row;
        s_cell_col    <= rq.cell_col;
    endtask

    // Offer one request and hold it until accepted. Called at a rising edge;
    // returns at the edge where the handshake took place.
    task automatic offer_request(input request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        put_payload(rq);
        do @(posedge aclk); while (!s_ready);
        board.note_request(rq);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle. Upper data bits of the
    // sheet sizes are random; the block must ignore them.
    task automatic program_sheet(input logic [ffgrp_pkg::DIM_W-1:0] rows,
                                 input logic [ffgrp_pkg::DIM_W-1:0] cols,
                                 input logic [ffgrp_pkg::TAGF_W-1:0] free);
        logic [ffgrp_pkg::CFG_IDX_W-1:0]  idx  [3];
        logic [ffgrp_pkg::CFG_DATA_W-1:0] data [3];
        int                               i;
        idx  = '{ffgrp_pkg::REG_STOCK_ROWS, ffgrp_pkg::REG_STOCK_COLS, ffgrp_pkg::REG_EMPTY_TAG};
        data[0] = {3'($urandom_range(0, 7)), rows};
        data[1] = {3'($urandom_range(0, 7)), cols};
        data[2] = free;
        for (i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
            board.write_register(idx[i], data[i]);
        end
        cfg_we   <= 1'b0;
        rows_now = (rows > GRID_ROWS) ? GRID_ROWS : int'(rows);
        cols_now = (cols > GRID_COLS) ? GRID_COLS : int'(cols);
        free_now = free;
    endtask

    // Result side: check every accepted result, then pick the next stall.
    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_result(m_placed, m_cell_value);
            if (hold_output) begin
                // long hold-off so the block fills up and stalls its input
                hold_output = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        request_t idle_rq;
        int       p, n;
        idle_rq = compose_request(ffgrp_pkg::OP_PLACE, 0, 0, 0, 1'b0, 0, 0);
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= ffgrp_pkg::REG_STOCK_ROWS;
        cfg_wdata <= '0;
        put_payload(idle_rq);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // hold off until the clearing sweep after reset is done
        do @(posedge aclk); while (!s_ready);

        // Directed part on the reset sheet: reset contents, full-sheet piece,
        // full grid, oversize, empty and cut pieces, tag equal to the free tag.
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE, 16, 16, 8'hFF, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0, 15, 15));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1,  1, 8'h01, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_CLEAR,  0,  0, 8'h00, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE, 17,  1, 8'h12, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1, 17, 8'h13, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  0,  3, 8'h14, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  3,  0, 8'h15, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1,  1, 8'h16, 1'b1,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE, 31, 31, 8'hFF, 1'b1, 15, 15));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1,  1, 8'h00, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  2,  3, 8'hA5, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  1,  2));
        offer_request(compose_request(OP_UNUSED,           31, 31, 8'hFF, 1'b1, 15, 15));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  0,  0));

        // Saturated rows, narrow sheet, new free tag without a clear: only the
        // old piece's cells count as free now.
        drain_results();
        program_sheet(5'd31, 5'd5, 8'hA5);
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  2,  3, 8'h3C, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  0,  2));
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1,  1, 8'h07, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  0, 10));
        offer_request(compose_request(ffgrp_pkg::OP_CLEAR,  0,  0, 8'h00, 1'b0,  0,  0));
        offer_request(compose_request(ffgrp_pkg::OP_READ,   0,  0, 8'h00, 1'b0,  9,  9));

        // Empty sheet: every placement fails.
        drain_results();
        program_sheet(5'd0, 5'd16, 8'hFF);
        offer_request(compose_request(ffgrp_pkg::OP_PLACE,  1,  1, 8'h01, 1'b0,  0,  0));

        // Random phases, one sheet setting each.
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            program_sheet(ffgrp_pkg::DIM_W'(PHASE_ROWS[p]), ffgrp_pkg::DIM_W'(PHASE_COLS[p]),
                          ffgrp_pkg::TAGF_W'(PHASE_FREE[p]));
            calm = (p % 3 == 2);
            for (n = 0; n < PHASE_ITEMS[p]; n++) begin
                if (p == 0 && n == PHASE_ITEMS[0] / 2)
                    hold_output = 1'b1;
                offer_request(random_request());
            end
        end

        drain_results();
        if (board.mismatches == 0 && board.pending_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
